### hdl/bas_pkg.sv
package bas_pkg;

    localparam int PRESSURE_WINDOW = 15;
    localparam int SPEED_WINDOW    = 15;
    localparam int CURVE_SEGMENTS  = 64;

    localparam int P_W      = 24;
    localparam int TIME_W   = 32;
    localparam int ALT_W    = 27;
    localparam int RATE_W   = 28;
    localparam int PTOT_W   = 28;
    localparam int STOT_W   = 32;
    localparam int RING_IDX_W = 4;
    localparam int SEG_W    = $clog2(CURVE_SEGMENTS);
    localparam int TAB_IDX_W = SEG_W + 1;
    localparam int OFF_W    = P_W - SEG_W;
    localparam int DIV_W    = 36;
    localparam int DVSR_W   = 32;
    localparam int MCAND_W  = 27;
    localparam int PROD_W   = MCAND_W + OFF_W;

    localparam longint ALT_TOP_L = 44330000;
    localparam logic signed [ALT_W-1:0]  ALT_TOP   = 27'sd44330000;
    localparam logic signed [ALT_W-1:0]  ALT_LOW   = -27'sd1000000;
    localparam logic [RATE_W-1:0]        SPEED_LIM = 28'd100000000;
    localparam logic [DIV_W-1:0]         SPEED_LIM_W = 36'd100000000;
    localparam logic [DVSR_W-1:0]        DIV_BY_P  = DVSR_W'(PRESSURE_WINDOW);
    localparam logic [DVSR_W-1:0]        DIV_BY_S  = DVSR_W'(SPEED_WINDOW);
    localparam logic [RING_IDX_W-1:0]    P_LAST    = RING_IDX_W'(PRESSURE_WINDOW - 1);
    localparam logic [RING_IDX_W-1:0]    S_LAST    = RING_IDX_W'(SPEED_WINDOW - 1);

    typedef logic [CURVE_SEGMENTS:0][ALT_W-1:0] alt_table_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MEAN  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_SPEED = 6'b001000,
        ST_CLIMB = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 0;
        b = 64'h1 << 62;
        for (int i = 0; i < 32; i++)
            if (b > v) b = b >> 2;
        for (int i = 0; i < 32; i++) begin
            if (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    function automatic longint unsigned log2_q32(input longint unsigned v);
        int unsigned n;
        longint unsigned m;
        longint unsigned frac;
        n = 0;
        frac = 0;
        for (int i = 0; i < 63; i++)
            if ((v >> n) > 1) n++;
        if (n >= 30) m = v >> (n - 30);
        else m = v << (30 - n);
        for (int k = 1; k <= 32; k++) begin
            m = (m * m) >> 30;
            if (m >= (64'h1 << 31)) begin
                m = m >> 1;
                frac = frac | (64'h1 << (32 - k));
            end
        end
        return (longint'(n) << 32) | frac;
    endfunction

    function automatic longint unsigned exp2_q30(input longint y);
        longint unsigned pc [0:32];
        longint unsigned u;
        longint unsigned f;
        longint unsigned r;
        int ip;
        pc[0] = 64'h2 << 30;
        pc[1] = isqrt64(64'h1 << 61);
        for (int i = 2; i <= 32; i++) pc[i] = isqrt64(pc[i-1] << 30);
        u = unsigned'(y + (longint'(32) << 32));
        ip = int'(u >> 32) - 32;
        f = u & 64'hFFFF_FFFF;
        r = 64'h1 << 30;
        for (int k = 1; k <= 32; k++)
            if (((f >> (32 - k)) & 64'h1) != 0) r = (r * pc[k]) >> 30;
        if (ip >= 0) begin
            if (ip > 8) ip = 8;
            r = r << ip;
        end else begin
            r = (-ip >= 63) ? 64'h0 : (r >> (-ip));
        end
        return r;
    endfunction

    function automatic alt_table_t build_curve();
        alt_table_t t;
        longint refv;
        longint d;
        longint y;
        longint a;
        longint unsigned p;
        longint unsigned w;
        refv = signed'(log2_q32(64'd10132500));
        for (int i = 0; i <= CURVE_SEGMENTS; i++) begin
            p = (longint'(i) << 24) / CURVE_SEGMENTS;
            if (p == 0) begin
                a = ALT_TOP_L;
            end else begin
                d = signed'(log2_q32(p)) - refv;
                y = d * 1903 / 10000;
                w = exp2_q30(y);
                a = ALT_TOP_L - signed'((unsigned'(ALT_TOP_L) * w) >> 30);
            end
            t[i] = a[ALT_W-1:0];
        end
        return t;
    endfunction

    localparam alt_table_t ALT_TABLE = build_curve();

endpackage

### hdl/bas_sdiv.sv
module bas_sdiv
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0]  quo_reg;
    logic [DVSR_W-1:0] rem_reg;
    logic [DVSR_W-1:0] dvsr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVSR_W:0]   rem_sh;
    logic [DVSR_W+1:0] trial;

    // shift one dividend bit into the partial remainder, try the subtract
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DVSR_W+1])
            begin
                rem_reg <= trial[DVSR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DVSR_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/bas_smul.sv
module bas_smul
    import bas_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MCAND_W-1:0] mcand,
    input  logic [OFF_W-1:0]   mplier,
    output logic               done,
    output logic [PROD_W-1:0]  product
);

    localparam int CNT_W = $clog2(OFF_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OFF_W - 1);

    logic [PROD_W-1:0]  acc_reg;
    logic [MCAND_W-1:0] mcand_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MCAND_W:0]   sum;

    // add the multiplicand under the low multiplier bit, then shift right
    assign sum = {1'b0, acc_reg[PROD_W-1:OFF_W]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= {{MCAND_W{1'b0}}, mplier};
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[OFF_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### hdl/baro_altitude_speed_estimator.sv
// Flow: while the pressure window fills, an accepted item goes from ST_IDLE through ST_OUT
// into the output register. Once the window is full, an item takes a divider pass for the
// window mean, the shift-add interpolation multiplier, a divider pass for the speed and one
// for the speed mean, each in its own state. Skip the speed pass on a zero interval, and the
// speed-mean pass until the speed window is full. One item in flight: the next item is
// taken the cycle after the result enters the output register, and a result held by the
// receiver stalls the input. Reset (rst_n low, asynchronous) clears the state, both rings,
// sums, indexes, the window-full flags, the held altitude and time, and the output valid.
module baro_altitude_speed_estimator
    import bas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [23:0] pressure_sample, [55:24] time_ms
    input  logic        s_tuser,   // [0] sample_valid
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [26:0] altitude_mm, [54:27] climb_rate, [55] zero
    output logic [1:0]  m_tuser    // [0] altitude_valid, [1] rate_valid
);

    state_t state_reg, state_next;

    // pressure window
    logic [P_W-1:0]        p_ring_reg [PRESSURE_WINDOW];
    logic [PTOT_W-1:0]     p_total_reg, p_total_next;
    logic [RING_IDX_W-1:0] tick_reg, tick_next;
    logic                  wfull_reg, wfull_next;
    logic                  p_wr_en;

    // altitude and speed history
    logic signed [ALT_W-1:0]  cur_alt_reg, cur_alt_next;
    logic [TIME_W-1:0]        prev_time_reg, prev_time_next;
    logic signed [RATE_W-1:0] s_ring_reg [SPEED_WINDOW];
    logic signed [STOT_W-1:0] s_total_reg, s_total_next;
    logic [RING_IDX_W-1:0]    s_idx_reg, s_idx_next;
    logic                     sfull_reg, sfull_next;
    logic                     s_wr_en;
    logic signed [RATE_W-1:0] speed_val;

    // per-item working registers
    logic [TIME_W-1:0]        time_reg, time_next;
    logic [SEG_W-1:0]         seg_reg, seg_next;
    logic                     neg_reg, neg_next;
    logic                     dzero_reg, dzero_next;
    logic                     av_reg, av_next;
    logic signed [RATE_W-1:0] climb_reg, climb_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg, m_data_next;
    logic [1:0]  m_user_reg, m_user_next;

    // serial units; the divider is shared by the three divisions
    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_dividend, div_q;
    logic [DVSR_W-1:0] div_divisor;
    logic              mul_start, mul_done;
    logic [MCAND_W-1:0] mul_mcand;
    logic [OFF_W-1:0]  mul_mplier;
    logic [PROD_W-1:0] mul_prod;

    bas_sdiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    bas_smul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb
    begin
        logic [PTOT_W-1:0]        ptot;
        logic [TAB_IDX_W-1:0]     seg_idx;
        logic signed [ALT_W-1:0]  a_lo, a_hi;
        logic signed [ALT_W:0]    delta;
        logic [ALT_W-1:0]         term_mag;
        logic signed [ALT_W:0]    term;
        logic signed [ALT_W+1:0]  alt_raw;
        logic signed [ALT_W-1:0]  alt;
        logic signed [ALT_W:0]    diff;
        logic [ALT_W:0]           diff_mag;
        logic [DIV_W-1:0]         dm;
        logic [TIME_W-1:0]        dt;
        logic [RATE_W-1:0]        spd_mag;
        logic signed [STOT_W-1:0] stot;
        logic [STOT_W-1:0]        stot_mag;

        state_next     = state_reg;
        p_total_next   = p_total_reg;
        tick_next      = tick_reg;
        wfull_next     = wfull_reg;
        p_wr_en        = 1'b0;
        cur_alt_next   = cur_alt_reg;
        prev_time_next = prev_time_reg;
        s_total_next   = s_total_reg;
        s_idx_next     = s_idx_reg;
        sfull_next     = sfull_reg;
        s_wr_en        = 1'b0;
        speed_val      = '0;
        time_next      = time_reg;
        seg_next       = seg_reg;
        neg_next       = neg_reg;
        dzero_next     = dzero_reg;
        av_next        = av_reg;
        climb_next     = climb_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        mul_start      = 1'b0;
        mul_mcand      = '0;
        mul_mplier     = '0;

        ptot     = p_total_reg;
        seg_idx  = '0;
        a_lo     = '0;
        a_hi     = '0;
        delta    = '0;
        term_mag = '0;
        term     = '0;
        alt_raw  = '0;
        alt      = '0;
        diff     = '0;
        diff_mag = '0;
        dm       = '0;
        dt       = '0;
        spd_mag  = '0;
        stot     = '0;
        stot_mag = '0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // drop the old entry from the sum, take the new sample
                    if (s_tuser)
                    begin
                        ptot = p_total_reg - PTOT_W'(p_ring_reg[tick_reg])
                             + PTOT_W'(s_tdata[P_W-1:0]);
                        p_wr_en = 1'b1;
                    end
                    p_total_next = ptot;
                    time_next    = s_tdata[P_W +: TIME_W];
                    if (tick_reg == P_LAST)
                    begin
                        tick_next  = '0;
                        wfull_next = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    if (wfull_next)
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(ptot);
                        div_divisor  = DIV_BY_P;
                        state_next   = ST_MEAN;
                    end
                    else
                    begin
                        av_next    = 1'b0;
                        climb_next = '0;
                        state_next = ST_OUT;
                    end
                end
            end

            ST_MEAN:
            begin
                if (div_done)
                begin
                    // segment from the top bits of the mean, offset from the rest
                    seg_next = div_q[P_W-1:OFF_W];
                    seg_idx  = {1'b0, div_q[P_W-1:OFF_W]};
                    a_lo     = signed'(ALT_TABLE[seg_idx]);
                    a_hi     = signed'(ALT_TABLE[seg_idx + 1'b1]);
                    delta    = {a_hi[ALT_W-1], a_hi} - {a_lo[ALT_W-1], a_lo};
                    neg_next = delta[ALT_W];
                    mul_start  = 1'b1;
                    mul_mcand  = delta[ALT_W] ? MCAND_W'(-delta) : MCAND_W'(delta);
                    mul_mplier = div_q[OFF_W-1:0];
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (mul_done)
                begin
                    seg_idx  = {1'b0, seg_reg};
                    a_lo     = signed'(ALT_TABLE[seg_idx]);
                    term_mag = mul_prod[PROD_W-1:OFF_W];
                    term     = neg_reg ? -signed'({1'b0, term_mag}) : signed'({1'b0, term_mag});
                    alt_raw  = {{2{a_lo[ALT_W-1]}}, a_lo} + {term[ALT_W], term};
                    if (alt_raw > signed'({{2{ALT_TOP[ALT_W-1]}}, ALT_TOP}))
                        alt = ALT_TOP;
                    else if (alt_raw < signed'({{2{ALT_LOW[ALT_W-1]}}, ALT_LOW}))
                        alt = ALT_LOW;
                    else
                        alt = alt_raw[ALT_W-1:0];

                    diff     = {alt[ALT_W-1], alt} - {cur_alt_reg[ALT_W-1], cur_alt_reg};
                    diff_mag = diff[ALT_W] ? ($unsigned(-diff)) : $unsigned(diff);
                    // times 1000 as 1024 - 16 - 8
                    dm = (DIV_W'(diff_mag) << 10) - (DIV_W'(diff_mag) << 4)
                       - (DIV_W'(diff_mag) << 3);
                    dt = time_reg - prev_time_reg;

                    cur_alt_next   = alt;
                    prev_time_next = time_reg;
                    neg_next       = diff[ALT_W];
                    dzero_next     = (dt == '0);
                    if (dt != '0)
                    begin
                        div_start    = 1'b1;
                        div_dividend = dm;
                        div_divisor  = dt;
                    end
                    state_next = ST_SPEED;
                end
            end

            ST_SPEED:
            begin
                if (dzero_reg || div_done)
                begin
                    if (dzero_reg)
                        spd_mag = '0;
                    else if (div_q > SPEED_LIM_W)
                        spd_mag = SPEED_LIM;
                    else
                        spd_mag = div_q[RATE_W-1:0];
                    speed_val = neg_reg ? -signed'(spd_mag) : signed'(spd_mag);

                    stot = s_total_reg - STOT_W'(s_ring_reg[s_idx_reg]) + STOT_W'(speed_val);
                    s_total_next = stot;
                    s_wr_en      = 1'b1;
                    if (s_idx_reg == S_LAST)
                    begin
                        s_idx_next = '0;
                        sfull_next = 1'b1;
                    end
                    else
                    begin
                        s_idx_next = s_idx_reg + 1'b1;
                    end
                    av_next = 1'b1;
                    if (sfull_next)
                    begin
                        stot_mag     = stot[STOT_W-1] ? $unsigned(-stot) : $unsigned(stot);
                        neg_next     = stot[STOT_W-1];
                        div_start    = 1'b1;
                        div_dividend = DIV_W'(stot_mag);
                        div_divisor  = DIV_BY_S;
                        state_next   = ST_CLIMB;
                    end
                    else
                    begin
                        climb_next = '0;
                        state_next = ST_OUT;
                    end
                end
            end

            ST_CLIMB:
            begin
                if (div_done)
                begin
                    climb_next = neg_reg ? -signed'(div_q[RATE_W-1:0])
                                         : signed'(div_q[RATE_W-1:0]);
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, climb_reg, av_reg ? cur_alt_reg : '0};
                    m_user_next  = {av_reg & sfull_reg, av_reg};
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p_total_reg   <= '0;
            tick_reg      <= '0;
            wfull_reg     <= 1'b0;
            cur_alt_reg   <= '0;
            prev_time_reg <= '0;
            s_total_reg   <= '0;
            s_idx_reg     <= '0;
            sfull_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < PRESSURE_WINDOW; i++) p_ring_reg[i] <= '0;
            for (int i = 0; i < SPEED_WINDOW; i++) s_ring_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            p_total_reg   <= p_total_next;
            tick_reg      <= tick_next;
            wfull_reg     <= wfull_next;
            cur_alt_reg   <= cur_alt_next;
            prev_time_reg <= prev_time_next;
            s_total_reg   <= s_total_next;
            s_idx_reg     <= s_idx_next;
            sfull_reg     <= sfull_next;
            m_valid_reg   <= m_valid_next;
            if (p_wr_en)
                p_ring_reg[tick_reg] <= s_tdata[P_W-1:0];
            if (s_wr_en)
                s_ring_reg[s_idx_reg] <= speed_val;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg   <= time_next;
        seg_reg    <= seg_next;
        neg_reg    <= neg_next;
        dzero_reg  <= dzero_next;
        av_reg     <= av_next;
        climb_reg  <= climb_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule
